@@ rtl/core/fsi_pkg.sv @@
// fsi_pkg: shared types, codes and constants of the fuzzy inference core.
// Holds the exp-table builder used at elaboration. No dependencies.
package fsi_pkg;

	// Default sizes.
	localparam int MAX_SETS_DEF  = 8;
	localparam int EXP_DEPTH_DEF = 64;

	// Iterative divider geometry, fixed by the field widths.
	localparam int DIV_NW = 64;
	localparam int DIV_DW = 48;
	localparam int DIV_QW = 16;

	// Configuration port.
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 24;
	localparam logic [CFG_IW-1:0] CFG_IN_KIND  = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_OUT_KIND = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_IN_CNT   = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_OUT_CNT  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_RULE_MAP = 3'd4;

	// Item codes.
	localparam logic OP_WRITE    = 1'b0;
	localparam logic OP_EVAL     = 1'b1;
	localparam logic SIDE_IN     = 1'b0;
	localparam logic SIDE_OUT    = 1'b1;
	localparam logic SHAPE_TRAP  = 1'b0;
	localparam logic SHAPE_GAUSS = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_IN_RD,
		ST_IN_SQ,
		ST_IN_CHK,
		ST_IN_DIV,
		ST_IN_LUT,
		ST_IN_RULE,
		ST_OUT_RD,
		ST_OUT_PREP,
		ST_OUT_MUL,
		ST_FIN_PREP,
		ST_FIN_CHK,
		ST_FIN_DIV,
		ST_DONE
	} state_t;

	// Gaussian degree for table index k: exp step s from a 21-term series,
	// applied k times to 1.0 in Q0.32, then reduced to Q0.16.
	function automatic logic [15:0] exp_degree(input int unsigned k, input logic [63:0] y);
		logic [63:0] term;
		logic [63:0] s;
		logic [63:0] v;
		longint      sum;
		term = 64'd1 << 32;
		sum  = longint'(term);
		for (int n = 1; n <= 20; n++) begin
			term = ((term * y) >> 32) / 64'(n);
			if ((n & 1) != 0)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		s = (sum < 0) ? 64'd0 : 64'(sum);
		v = 64'd1 << 32;
		for (int unsigned i = 0; i < k; i++)
			v = (v * s) >> 32;
		v = v >> 16;
		return (v > 64'd65535) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

@@ rtl/core/fsi_mem.sv @@
// fsi_mem: shape word table, one write port, one read port, registered read.
// Depends on nothing.
module fsi_mem #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic signed [15:0]       wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic signed [15:0]       rdata
);

	logic signed [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/fsi_div.sv @@
// fsi_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on fsi_pkg for its widths. Caller keeps num below den << DIV_QW.
module fsi_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fsi_pkg::DIV_NW-1:0]   num,
	input  logic [fsi_pkg::DIV_DW-1:0]   den,
	output logic                         done,
	output logic [fsi_pkg::DIV_QW-1:0]   quot
);

	localparam int NW = fsi_pkg::DIV_NW;
	localparam int QW = fsi_pkg::DIV_QW;
	localparam int CW = $clog2(QW + 1);

	logic [NW-1:0] rem_q;
	logic [NW-1:0] dsh_q;
	logic [QW-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;

	assign ge   = rem_q >= dsh_q;
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= NW'(den) << (QW - 1);
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			quot_q <= {quot_q[QW-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

endmodule

@@ rtl/core/fuzzy_single_input_inference_core.sv @@
// fuzzy_single_input_inference_core: single-input fuzzy system, centroid result.
// Evaluate: each input set takes 4 word reads and at most one 16-step divide,
// each output set 4 word reads and shared multiplier steps, then a final divide
// runs unless the denominator is zero or the result saturates.
// One item at a time; a finished result waits in the output register.
// Reset (arst_n, async) restores config defaults; shape tables stay unwritten.
module fuzzy_single_input_inference_core #(
	parameter int MAX_SETS        = fsi_pkg::MAX_SETS_DEF,
	parameter int EXP_TABLE_DEPTH = fsi_pkg::EXP_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fsi_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [fsi_pkg::CFG_DW-1:0]  cfg_data,
	// input items
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic                        table_side,
	input  logic [2:0]                  set_index,
	input  logic [1:0]                  point_index,
	input  logic signed [15:0]          word_value,
	input  logic signed [15:0]          x_value,
	// result items
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [15:0]          crisp_out,
	output logic                        no_activation
);

	localparam int DEPTH = 4 * MAX_SETS;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(EXP_TABLE_DEPTH);
	localparam int LIM   = (MAX_SETS < 8) ? MAX_SETS : 8;
	localparam logic [3:0]  LIM4  = 4'(LIM);
	localparam logic [63:0] EXP_Y = (64'd8 << 32) / EXP_TABLE_DEPTH;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic        in_kind_q, out_kind_q;
	logic [3:0]  in_cnt_q, out_cnt_q;
	logic [23:0] rule_q;
	logic [3:0]  nin, nout;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_kind_q  <= fsi_pkg::SHAPE_TRAP;
			out_kind_q <= fsi_pkg::SHAPE_TRAP;
			in_cnt_q   <= 4'd1;
			out_cnt_q  <= 4'd1;
			rule_q     <= 24'd16434824;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fsi_pkg::CFG_IN_KIND:  in_kind_q  <= cfg_data[0];
				fsi_pkg::CFG_OUT_KIND: out_kind_q <= cfg_data[0];
				fsi_pkg::CFG_IN_CNT:   in_cnt_q   <= cfg_data[3:0];
				fsi_pkg::CFG_OUT_CNT:  out_cnt_q  <= cfg_data[3:0];
				fsi_pkg::CFG_RULE_MAP: rule_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Counts clamp to the table size or to 8, whichever is smaller.
	assign nin  = (in_cnt_q > LIM4) ? LIM4 : in_cnt_q;
	assign nout = (out_cnt_q > LIM4) ? LIM4 : out_cnt_q;

	// ---------------------------------------------------------------
	// Handshake and state
	// ---------------------------------------------------------------
	fsi_pkg::state_t state_q, state_d;
	logic in_acc, eval_acc, wr_acc;
	logic out_valid_q;

	assign in_ready = (state_q == fsi_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign eval_acc = in_acc && (operation == fsi_pkg::OP_EVAL);
	// writes to sets past the table are dropped
	assign wr_acc   = in_acc && (operation == fsi_pkg::OP_WRITE) && (int'(set_index) < MAX_SETS);

	// ---------------------------------------------------------------
	// Shape tables: word address = 4 * set + point
	// ---------------------------------------------------------------
	logic                 we_in, we_out;
	logic [AW-1:0]        waddr, raddr;
	logic signed [15:0]   rd_in, rd_out, rd_word;
	logic [3:0]           si_q;
	logic [2:0]           rc_q;

	assign we_in  = wr_acc && (table_side == fsi_pkg::SIDE_IN);
	assign we_out = wr_acc && (table_side == fsi_pkg::SIDE_OUT);
	assign waddr  = AW'({set_index, point_index});
	assign raddr  = AW'({si_q[2:0], rc_q[1:0]});

	fsi_mem #(.DEPTH(DEPTH)) u_in_mem (
		.clk   (clk),
		.we    (we_in),
		.waddr (waddr),
		.wdata (word_value),
		.raddr (raddr),
		.rdata (rd_in)
	);

	fsi_mem #(.DEPTH(DEPTH)) u_out_mem (
		.clk   (clk),
		.we    (we_out),
		.waddr (waddr),
		.wdata (word_value),
		.raddr (raddr),
		.rdata (rd_out)
	);

	assign rd_word = (state_q == fsi_pkg::ST_OUT_RD) ? rd_out : rd_in;

	// ---------------------------------------------------------------
	// Exp table for gaussian degrees, built at elaboration
	// ---------------------------------------------------------------
	logic [15:0] exp_lut [EXP_TABLE_DEPTH];

	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_lut
		localparam logic [15:0] LV = fsi_pkg::exp_degree(g, EXP_Y);
		assign exp_lut[g] = LV;
	end

	// ---------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------
	logic signed [15:0] x_q;
	logic signed [15:0] w_q [4];
	logic [15:0]        h_q;
	logic [15:0]        deg_q [8];
	logic [32:0]        dx2_q;
	logic [31:0]        s2_q;

	logic signed [16:0] A_q, B_q, C_q;
	logic signed [17:0] W_q;
	logic signed [15:0] a_q, sg_q;
	logic [15:0]        hm_q;
	logic [2:0]         mc_q;
	logic signed [39:0] m_q;
	logic signed [59:0] n_q;
	logic signed [41:0] d_q;

	logic [60:0]        fn_q;
	logic [41:0]        fd_q;
	logic               fneg_q;
	logic signed [15:0] res_q, crisp_q;
	logic               res_na_q, na_q;

	// Input-side combinational terms
	logic signed [16:0] dx, d_xa, d_ba, d_dx, d_dc;
	logic signed [33:0] dx_sq;
	logic signed [31:0] sg_sq;
	logic               t_out, t_up, t_flat, g_zero;
	logic [2:0]         tgt;
	logic               last_in, last_out;

	assign dx    = 17'(x_q) - 17'(w_q[0]);
	assign d_xa  = 17'(x_q) - 17'(w_q[0]);
	assign d_ba  = 17'(w_q[1]) - 17'(w_q[0]);
	assign d_dx  = 17'(w_q[3]) - 17'(x_q);
	assign d_dc  = 17'(w_q[3]) - 17'(w_q[2]);
	assign dx_sq = dx * dx;
	assign sg_sq = w_q[1] * w_q[1];

	assign t_out  = (x_q < w_q[0]) || (x_q > w_q[3]);
	assign t_up   = x_q < w_q[1];
	assign t_flat = x_q <= w_q[2];
	// z*z/2 at or past 8 (dx^2 >= 16 sigma^2) or a bad sigma: zero degree
	assign g_zero = (w_q[1] <= 16'sd0) || ({3'b000, dx2_q} >= {s2_q, 4'h0});

	assign tgt      = rule_q[5'(si_q[2:0]) * 5'd3 +: 3];
	assign last_in  = (si_q + 4'd1) == nin;
	assign last_out = (si_q + 4'd1) == nout;

	// Output-side terms: A = c-b, B = d-a, C = b-a
	logic signed [16:0] A_c, B_c, C_c;
	assign A_c = 17'(w_q[2]) - 17'(w_q[1]);
	assign B_c = 17'(w_q[3]) - 17'(w_q[0]);
	assign C_c = 17'(w_q[1]) - 17'(w_q[0]);

	// Shared multiplier, one product per step of the output-set sequence.
	logic signed [39:0] ma;
	logic signed [17:0] mb;
	logic signed [57:0] prod;
	logic signed [59:0] prod3;
	logic signed [17:0] hm_s;
	logic               o_gauss;

	assign o_gauss = (out_kind_q == fsi_pkg::SHAPE_GAUSS);
	assign hm_s    = $signed({2'b00, hm_q});

	always_comb begin
		ma = 40'(A_q);
		mb = 18'(C_q);
		case (mc_q)
			3'd0: begin
				ma = o_gauss ? 40'(a_q) : 40'(A_q);
				mb = o_gauss ? 18'(sg_q) : 18'(C_q);
			end
			3'd1: begin ma = 40'(A_q); mb = 18'(A_q); end
			3'd2: begin ma = 40'(C_q); mb = 18'(B_q); end
			3'd3: begin ma = 40'(A_q); mb = 18'(B_q); end
			3'd4: begin ma = 40'(B_q); mb = 18'(B_q); end
			3'd5: begin ma = 40'(a_q); mb = W_q; end
			3'd6: begin ma = m_q; mb = hm_s; end
			default: begin
				ma = o_gauss ? 40'(sg_q) : 40'(W_q);
				mb = hm_s;
			end
		endcase
	end

	assign prod  = ma * mb;
	assign prod3 = 60'(prod) + (60'(prod) <<< 1);

	// Final rounding: magnitudes and sign of n/d
	logic [59:0] nabs;
	logic [41:0] dabs;
	assign nabs = n_q[59] ? 60'(-n_q) : 60'(n_q);
	assign dabs = d_q[41] ? 42'(-d_q) : 42'(d_q);

	// ---------------------------------------------------------------
	// Divider, shared by trapezoid ramps, gaussian index and the result
	// ---------------------------------------------------------------
	logic                       div_start, div_done;
	logic [fsi_pkg::DIV_NW-1:0] div_num;
	logic [fsi_pkg::DIV_DW-1:0] div_den;
	logic [fsi_pkg::DIV_QW-1:0] div_quot;

	fsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// ---------------------------------------------------------------
	// Sequencer: next state and divider requests
	// ---------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = 64'({d_xa[15:0], 16'h0000});
		div_den   = 48'(d_ba[16:0]);
		unique case (state_q)
			fsi_pkg::ST_IDLE: begin
				if (eval_acc) begin
					if (nin != 4'd0)
						state_d = fsi_pkg::ST_IN_RD;
					else if (nout != 4'd0)
						state_d = fsi_pkg::ST_OUT_RD;
					else
						state_d = fsi_pkg::ST_FIN_PREP;
				end
			end
			fsi_pkg::ST_IN_RD: begin
				if (rc_q == 3'd4)
					state_d = fsi_pkg::ST_IN_SQ;
			end
			fsi_pkg::ST_IN_SQ: state_d = fsi_pkg::ST_IN_CHK;
			fsi_pkg::ST_IN_CHK: begin
				if (in_kind_q == fsi_pkg::SHAPE_GAUSS) begin
					div_num = 64'(dx2_q) * 64'(EXP_TABLE_DEPTH);
					div_den = 48'({s2_q, 4'h0});
					if (g_zero) begin
						state_d = fsi_pkg::ST_IN_RULE;
					end else begin
						div_start = 1'b1;
						state_d   = fsi_pkg::ST_IN_DIV;
					end
				end else begin
					if (t_out || (!t_up && t_flat)) begin
						state_d = fsi_pkg::ST_IN_RULE;
					end else begin
						// rising ramp, or falling ramp past c
						if (!t_up) begin
							div_num = 64'({d_dx[15:0], 16'h0000});
							div_den = 48'(d_dc[16:0]);
						end
						div_start = 1'b1;
						state_d   = fsi_pkg::ST_IN_DIV;
					end
				end
			end
			fsi_pkg::ST_IN_DIV: begin
				if (div_done)
					state_d = (in_kind_q == fsi_pkg::SHAPE_GAUSS) ?
						fsi_pkg::ST_IN_LUT : fsi_pkg::ST_IN_RULE;
			end
			fsi_pkg::ST_IN_LUT: state_d = fsi_pkg::ST_IN_RULE;
			fsi_pkg::ST_IN_RULE: begin
				if (!last_in)
					state_d = fsi_pkg::ST_IN_RD;
				else if (nout != 4'd0)
					state_d = fsi_pkg::ST_OUT_RD;
				else
					state_d = fsi_pkg::ST_FIN_PREP;
			end
			fsi_pkg::ST_OUT_RD: begin
				if (rc_q == 3'd4)
					state_d = fsi_pkg::ST_OUT_PREP;
			end
			fsi_pkg::ST_OUT_PREP: state_d = fsi_pkg::ST_OUT_MUL;
			fsi_pkg::ST_OUT_MUL: begin
				if (mc_q == 3'd7)
					state_d = last_out ? fsi_pkg::ST_FIN_PREP : fsi_pkg::ST_OUT_RD;
			end
			fsi_pkg::ST_FIN_PREP: begin
				state_d = (d_q == 42'sd0) ? fsi_pkg::ST_DONE : fsi_pkg::ST_FIN_CHK;
			end
			fsi_pkg::ST_FIN_CHK: begin
				div_num = 64'(fn_q);
				div_den = 48'(fd_q);
				if (fn_q >= 61'({fd_q, 16'h0000})) begin
					state_d = fsi_pkg::ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = fsi_pkg::ST_FIN_DIV;
				end
			end
			fsi_pkg::ST_FIN_DIV: begin
				if (div_done)
					state_d = fsi_pkg::ST_DONE;
			end
			fsi_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready)
					state_d = fsi_pkg::ST_IDLE;
			end
			default: state_d = fsi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsi_pkg::ST_IDLE;
			rc_q    <= '0;
			si_q    <= '0;
			mc_q    <= '0;
		end else begin
			state_q <= state_d;
			// word read counter runs only inside a read burst
			if ((state_q == fsi_pkg::ST_IN_RD) || (state_q == fsi_pkg::ST_OUT_RD))
				rc_q <= (rc_q == 3'd4) ? 3'd0 : rc_q + 3'd1;
			else
				rc_q <= '0;
			if (eval_acc)
				si_q <= '0;
			else if (state_q == fsi_pkg::ST_IN_RULE)
				si_q <= last_in ? 4'd0 : si_q + 4'd1;
			else if ((state_q == fsi_pkg::ST_OUT_MUL) && (mc_q == 3'd7))
				si_q <= si_q + 4'd1;
			if (state_q == fsi_pkg::ST_OUT_MUL)
				mc_q <= (o_gauss && (mc_q == 3'd0)) ? 3'd6 : mc_q + 3'd1;
			else
				mc_q <= '0;
		end
	end

	// ---------------------------------------------------------------
	// Datapath updates
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (eval_acc) begin
			x_q <= x_value;
			n_q <= '0;
			d_q <= '0;
			for (int i = 0; i < 8; i++)
				deg_q[i] <= '0;
		end

		// read data arrives in the cycle after its address
		if (((state_q == fsi_pkg::ST_IN_RD) || (state_q == fsi_pkg::ST_OUT_RD)) &&
		    (rc_q != 3'd0))
			w_q[rc_q[1:0] - 2'd1] <= rd_word;

		case (state_q)
			fsi_pkg::ST_IN_SQ: begin
				dx2_q <= 33'(dx_sq);
				s2_q  <= 32'(sg_sq);
			end
			fsi_pkg::ST_IN_CHK: begin
				if (in_kind_q == fsi_pkg::SHAPE_GAUSS)
					h_q <= 16'h0000;
				else if (t_out)
					h_q <= 16'h0000;
				else
					h_q <= 16'hFFFF;
			end
			fsi_pkg::ST_IN_DIV: begin
				if (div_done && (in_kind_q == fsi_pkg::SHAPE_TRAP))
					h_q <= div_quot;
			end
			fsi_pkg::ST_IN_LUT: h_q <= exp_lut[div_quot[KW-1:0]];
			fsi_pkg::ST_IN_RULE: begin
				// later input sets overwrite earlier ones on a shared target
				if ({1'b0, tgt} < nout)
					deg_q[tgt] <= h_q;
			end
			fsi_pkg::ST_OUT_PREP: begin
				A_q  <= A_c;
				B_q  <= B_c;
				C_q  <= C_c;
				W_q  <= 18'(A_c) + 18'(B_c);
				a_q  <= w_q[0];
				sg_q <= w_q[1];
				// gaussian with sigma <= 0 contributes nothing
				hm_q <= (o_gauss && (w_q[1] <= 16'sd0)) ? 16'h0000 : deg_q[si_q[2:0]];
			end
			fsi_pkg::ST_OUT_MUL: begin
				case (mc_q)
					3'd0:    m_q <= o_gauss ? 40'(prod) : (40'(prod) <<< 1);
					3'd5:    m_q <= m_q + 40'(prod3);
					3'd6:    n_q <= n_q + 60'(prod);
					3'd7:    d_q <= d_q + (o_gauss ? 42'(prod) : 42'(prod3));
					default: m_q <= m_q + 40'(prod);
				endcase
			end
			fsi_pkg::ST_FIN_PREP: begin
				fn_q     <= 61'(nabs) + 61'(dabs >> 1);
				fd_q     <= dabs;
				fneg_q   <= n_q[59] ^ d_q[41];
				res_q    <= 16'sd0;
				res_na_q <= (d_q == 42'sd0);
			end
			fsi_pkg::ST_FIN_CHK: begin
				res_q <= fneg_q ? 16'sh8000 : 16'sh7FFF;
			end
			fsi_pkg::ST_FIN_DIV: begin
				if (fneg_q)
					res_q <= div_quot[15] ? 16'sh8000 : $signed(16'(~div_quot + 16'd1));
				else
					res_q <= div_quot[15] ? 16'sh7FFF : $signed(div_quot);
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == fsi_pkg::ST_DONE) && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == fsi_pkg::ST_DONE) && (!out_valid_q || out_ready)) begin
			crisp_q <= res_q;
			na_q    <= res_na_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign crisp_out     = crisp_q;
	assign no_activation = na_q;

endmodule

@@ dv/fuzzy_single_input_inference_core_test.sv @@
// Self-checking bench for fuzzy_single_input_inference_core: random shape loads
// and evaluations under several register settings, checked by a cycle-free predictor.
// Depends on fsi_pkg and the core RTL.
`timescale 1ns / 100ps

module fuzzy_single_input_inference_core_test;

	localparam int NSETS      = 8;
	localparam int EXP_DEPTH  = 64;
	localparam int CYCLE_CAP  = 3000000;
	localparam int HOLD_LEN   = 600;

	typedef struct {
		logic               op;
		logic               side;
		logic [2:0]         set;
		logic [1:0]         pt;
		logic signed [15:0] word;
		logic signed [15:0] x;
	} fz_item_t;

	typedef struct {
		logic signed [15:0] crisp;
		logic               noact;
	} fz_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [fsi_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [fsi_pkg::CFG_DW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic table_side = 1'b0;
	logic [2:0] set_index = '0;
	logic [1:0] point_index = '0;
	logic signed [15:0] word_value = '0;
	logic signed [15:0] x_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] crisp_out;
	logic no_activation;

	fuzzy_single_input_inference_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.table_side(table_side), .set_index(set_index), .point_index(point_index),
		.word_value(word_value), .x_value(x_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.crisp_out(crisp_out), .no_activation(no_activation)
	);

	// Mirror of the block's registers and shape tables
	logic               m_in_kind = fsi_pkg::SHAPE_TRAP;
	logic               m_out_kind = fsi_pkg::SHAPE_TRAP;
	logic [3:0]         m_in_cnt = 4'd1;
	logic [3:0]         m_out_cnt = 4'd1;
	logic [23:0]        m_rule = 24'hFAC688;
	logic signed [15:0] in_words[4*NSETS];
	logic signed [15:0] out_words[4*NSETS];

	fz_item_t   pending_q[$];
	fz_result_t crisp_q[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int hold_left = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// ---- predictor -------------------------------------------------------

	// Per-step decay exp(-8/depth) in Q0.32 from the integer Taylor series.
	function automatic longint unsigned decay_step();
		longint unsigned y, term;
		longint sum;
		y = (64'd8 << 32) / EXP_DEPTH;
		term = 64'd1 << 32;
		sum = longint'(term);
		for (int n = 1; n <= 20; n++) begin
			term = ((term * y) >> 32) / n;
			if (n % 2 == 1)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		return (sum < 0) ? 64'd0 : longint'(sum);
	endfunction

	function automatic int unsigned gauss_degree(longint x, longint mean, longint sigma);
		longint dx;
		longint unsigned num, den, k, v, s;
		if (sigma <= 0)
			return 0;
		dx = x - mean;
		num = longint'(dx * dx) * EXP_DEPTH;
		den = 16 * sigma * sigma;
		k = num / den;
		if (k >= EXP_DEPTH)
			return 0;
		s = decay_step();
		v = 64'd1 << 32;
		for (longint unsigned i = 0; i < k; i++)
			v = (v * s) >> 32;
		v = v >> 16;
		return (v > 65535) ? 65535 : int'(v);
	endfunction

	function automatic int unsigned trap_degree(longint x, longint a, longint b,
			longint c, longint d);
		if (x < a || x > d)
			return 0;
		if (x < b)
			return int'(((x - a) * 65536) / (b - a));
		if (x <= c)
			return 65535;
		return int'(((d - x) * 65536) / (d - c));
	endfunction

	// Round to nearest, ties away from zero, magnitude capped.
	function automatic longint round_quot(longint n, longint d);
		longint unsigned mag, q;
		logic neg;
		if (d < 0) begin
			d = -d;
			n = -n;
		end
		neg = (n < 0);
		mag = neg ? -n : n;
		q = (mag + d / 2) / d;
		if (q > 40000)
			q = 40000;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic fz_result_t centroid_of(logic signed [15:0] xin);
		int unsigned deg[NSETS];
		int nin, nout, t;
		longint x, num, den, h, q, a, ca, cb, cc, w, m;
		fz_result_t r;
		x = xin;
		num = 0;
		den = 0;
		nin = (m_in_cnt > NSETS) ? NSETS : m_in_cnt;
		nout = (m_out_cnt > NSETS) ? NSETS : m_out_cnt;
		foreach (deg[i]) deg[i] = 0;
		for (int i = 0; i < nin; i++) begin
			t = (m_rule >> (3 * i)) & 7;
			h = (m_in_kind == fsi_pkg::SHAPE_GAUSS)
				? gauss_degree(x, in_words[4*i], in_words[4*i+1])
				: trap_degree(x, in_words[4*i], in_words[4*i+1],
					in_words[4*i+2], in_words[4*i+3]);
			// later input sets overwrite earlier ones on a shared target
			if (t < nout)
				deg[t] = 32'(h);
		end
		for (int i = 0; i < nout; i++) begin
			h = deg[i];
			if (m_out_kind == fsi_pkg::SHAPE_GAUSS) begin
				if (out_words[4*i+1] > 0) begin
					num += longint'(out_words[4*i]) * out_words[4*i+1] * h;
					den += longint'(out_words[4*i+1]) * h;
				end
			end else begin
				a = out_words[4*i];
				ca = longint'(out_words[4*i+2]) - out_words[4*i+1];
				cb = longint'(out_words[4*i+3]) - out_words[4*i];
				cc = longint'(out_words[4*i+1]) - out_words[4*i];
				w = ca + cb;
				m = 2*ca*cc + ca*ca + cc*cb + ca*cb + cb*cb + 3*a*w;
				num += m * h;
				den += w * h;
			end
		end
		if (m_out_kind == fsi_pkg::SHAPE_TRAP)
			den *= 3;
		if (den == 0) begin
			r.crisp = '0;
			r.noact = 1'b1;
		end else begin
			q = round_quot(num, den);
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			r.crisp = q[15:0];
			r.noact = 1'b0;
		end
		return r;
	endfunction

	// ---- driver: presents queued transactions, predicts on acceptance -----
	always @(posedge clk or negedge arst_n) begin
		fz_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (operation == fsi_pkg::OP_WRITE) begin
					if (table_side == fsi_pkg::SIDE_OUT)
						out_words[4*set_index + point_index] = word_value;
					else
						in_words[4*set_index + point_index] = word_value;
				end else begin
					crisp_q = {crisp_q, centroid_of(x_value)};
				end
			end
			if (!in_valid || in_ready) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					it = pending_q.pop_front();
					in_valid <= 1'b1;
					operation <= it.op;
					table_side <= it.side;
					set_index <= it.set;
					point_index <= it.pt;
					word_value <= it.word;
					x_value <= it.x;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---- monitor: random back-pressure, compares against oldest expectation
	always @(posedge clk or negedge arst_n) begin
		fz_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (crisp_q.size() == 0) begin
					$display("%0t ERROR unexpected result crisp_out %0d no_activation %0b",
						$time, crisp_out, no_activation);
					errors++;
				end else begin
					e = crisp_q.pop_front();
					if (crisp_out !== e.crisp) begin
						$display("%0t ERROR crisp_out expected %0d actual %0d",
							$time, e.crisp, crisp_out);
						errors++;
					end
					if (no_activation !== e.noact) begin
						$display("%0t ERROR no_activation expected %0b actual %0b",
							$time, e.noact, no_activation);
						errors++;
					end
				end
			end
			// long hold-off lets the core fill up and stall its input
			if (hold_req && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left <= HOLD_LEN;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("FAIL fuzzy_single_input_inference_core");
			$finish;
		end
	end

	// ---- stimulus --------------------------------------------------------

	task automatic cfg_write(logic [fsi_pkg::CFG_IW-1:0] idx,
			logic [fsi_pkg::CFG_DW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			fsi_pkg::CFG_IN_KIND:  m_in_kind = val[0];
			fsi_pkg::CFG_OUT_KIND: m_out_kind = val[0];
			fsi_pkg::CFG_IN_CNT:   m_in_cnt = val[3:0];
			fsi_pkg::CFG_OUT_CNT:  m_out_cnt = val[3:0];
			fsi_pkg::CFG_RULE_MAP: m_rule = val[23:0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic ik, logic ok, logic [3:0] ic, logic [3:0] oc,
			logic [23:0] rm);
		cfg_write(fsi_pkg::CFG_IN_KIND, {23'd0, ik});
		cfg_write(fsi_pkg::CFG_OUT_KIND, {23'd0, ok});
		cfg_write(fsi_pkg::CFG_IN_CNT, {20'd0, ic});
		cfg_write(fsi_pkg::CFG_OUT_CNT, {20'd0, oc});
		cfg_write(fsi_pkg::CFG_RULE_MAP, rm);
	endtask

	task automatic push_write(logic side, int set, int pt, int val);
		fz_item_t it;
		it.op = fsi_pkg::OP_WRITE;
		it.side = side;
		it.set = 3'(set);
		it.pt = 2'(pt);
		it.word = 16'(val);
		it.x = 16'($urandom);
		pending_q = {pending_q, it};
	endtask

	task automatic push_eval(int val);
		fz_item_t it;
		it.op = fsi_pkg::OP_EVAL;
		it.side = 1'($urandom);
		it.set = 3'($urandom);
		it.pt = 2'($urandom);
		it.word = 16'($urandom);
		it.x = 16'(val);
		pending_q = {pending_q, it};
	endtask

	// A whole set with non-descending points; as a gaussian its sigma may be <= 0
	task automatic push_shape(logic side, int set);
		int p;
		p = $urandom_range(8192) - 4096;
		for (int k = 0; k < 4; k++) begin
			push_write(side, set, k, p);
			p = p + $urandom_range(1500);
			if (p > 32767) p = 32767;
		end
	endtask

	task automatic push_random();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			push_shape(1'($urandom), $urandom_range(7));
		else if (r < 22)
			push_write(1'($urandom), $urandom_range(7), $urandom_range(3), $urandom);
		else if (r < 55)
			push_eval($urandom);
		else
			push_eval($urandom_range(12000) - 6000);
	endtask

	// Wait until every result is back, then let a pending write settle.
	task automatic drain();
		while (pending_q.size() != 0 || in_valid || crisp_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int a;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load every word of both tables so no evaluation reads an unwritten one
		for (int s = 0; s < NSETS; s++) begin
			a = -4096 + s * 1024;
			for (int k = 0; k < 4; k++) begin
				push_write(fsi_pkg::SIDE_IN, s, k, a + 256 * k + (k == 3 ? 256 : 0));
				push_write(fsi_pkg::SIDE_OUT, s, k, a + 300 * k);
			end
		end
		// Directed: reset settings, then all eight sets
		push_eval(-32768);
		push_eval(32767);
		push_eval(-4096);
		drain();
		set_all(fsi_pkg::SHAPE_TRAP, fsi_pkg::SHAPE_TRAP, 4'd8, 4'd8, 24'hFAC688);
		push_eval(-4096);
		push_eval(-3840);
		push_eval(-3584);
		push_eval(-3072);
		push_eval(-3000);
		push_eval(0);
		push_eval(32767);
		push_eval(-32768);
		// unsorted trapezoids: the first point lies above the last
		push_write(fsi_pkg::SIDE_IN, 1, 0, 1000);
		push_write(fsi_pkg::SIDE_IN, 1, 3, -1000);
		push_write(fsi_pkg::SIDE_OUT, 2, 0, 2000);
		push_write(fsi_pkg::SIDE_OUT, 2, 3, -2000);
		push_eval(-2900);
		// extreme words
		push_write(fsi_pkg::SIDE_OUT, 0, 3, 32767);
		push_write(fsi_pkg::SIDE_OUT, 0, 0, -32768);
		push_eval(-4000);
		drain();
		// gaussian sets, some with zero or negative sigma
		set_all(fsi_pkg::SHAPE_GAUSS, fsi_pkg::SHAPE_GAUSS, 4'd8, 4'd8, 24'hFAC688);
		push_write(fsi_pkg::SIDE_IN, 4, 1, 0);
		push_eval(0);
		push_eval(-1024);
		push_eval(2000);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			if (ph < 3) begin
				send_idle <= 19;
				recv_idle <= 74;
			end else if (ph < 6) begin
				send_idle <= 74;
				recv_idle <= 19;
			end else begin
				send_idle <= 0;
				recv_idle <= 0;
			end
			case (ph)
				0: set_all(fsi_pkg::SHAPE_TRAP, fsi_pkg::SHAPE_TRAP, 4'd8, 4'd8,
					24'hFAC688);
				1: set_all(fsi_pkg::SHAPE_GAUSS, fsi_pkg::SHAPE_TRAP, 4'd1, 4'd1,
					24'h000000);
				// zero input sets, then counts beyond the table size
				2: set_all(fsi_pkg::SHAPE_TRAP, fsi_pkg::SHAPE_GAUSS, 4'd0, 4'd15,
					24'hFFFFFF);
				3: set_all(fsi_pkg::SHAPE_GAUSS, fsi_pkg::SHAPE_GAUSS, 4'd15, 4'd0,
					24'($urandom));
				default: set_all(1'($urandom), 1'($urandom), 4'($urandom_range(15)),
					4'($urandom_range(15)), 24'($urandom));
			endcase
			if (ph == 6)
				hold_req <= 1'b1;
			repeat (144) push_random();
			drain();
		end

		if (errors == 0)
			$display("PASS fuzzy_single_input_inference_core");
		else
			$display("FAIL fuzzy_single_input_inference_core");
		$finish;
	end

endmodule
